### rtl/kttx_pkg.sv
// Package for the keyed trace table: command codes, status codes, sizes.
// Used by every module of the table.
`default_nettype none
package kttx_pkg;
	localparam int ENTRIES_DEF   = 32;
	localparam int KEY_BITS_DEF  = 64;
	localparam int TIME_BITS_DEF = 32;
	localparam int LEVEL_BITS    = 9;
	localparam logic [3:0] LEVEL_STEP = 4'd10;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_DUP     = 3'd2,
		ST_FULL    = 3'd3,
		ST_MISSING = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_WALK = 2'd1,
		FSM_DONE = 2'd2
	} fsm_t;
endpackage
`default_nettype wire

### rtl/kttx_cell.sv
// One table slot of the keyed trace table. Slots form a ring that rotates one
// place per cycle during a walk; the cell at the head is examined and edited.
// Depends on kttx_pkg.
`default_nettype none
module kttx_cell
	import kttx_pkg::*;
#(
	parameter int KEY_BITS  = KEY_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  shift,
	input  wire logic                  in_used,
	input  wire logic [KEY_BITS-1:0]   in_key,
	input  wire logic [TIME_BITS-1:0]  in_exp,
	input  wire logic                  in_unl,
	input  wire logic                  in_rule,
	input  wire logic [LEVEL_BITS-1:0] in_lvl,
	output logic                       used_q,
	output logic [KEY_BITS-1:0]        key_q,
	output logic [TIME_BITS-1:0]       exp_q,
	output logic                       unl_q,
	output logic                       rule_q,
	output logic [LEVEL_BITS-1:0]      lvl_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (shift) begin
			used_q <= in_used;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q  <= in_key;
			exp_q  <= in_exp;
			unl_q  <= in_unl;
			rule_q <= in_rule;
			lvl_q  <= in_lvl;
		end
	end
endmodule
`default_nettype wire

### rtl/keyed_trace_table_with_expiry.sv
// Keyed trace table with expiry. Every command (add, delete, lookup, tick)
// rotates the ENTRIES-slot ring once through its head cell, one slot per
// cycle, then presents one result. An add that finds no duplicate and a
// free slot needs a second lap to fill that slot. A result that is not
// taken holds the table in its last state until the output register
// frees. A new request is taken while the previous result waits in the
// output register. Reset empties the table at once.
`default_nettype none
module keyed_trace_table_with_expiry
	import kttx_pkg::*;
#(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// kind[1:0], key[65:2], expire_time[97:66], now_time[129:98],
	// test_rule[130], level[138:131], check_start[139], sub_key_present[140]
	input  wire logic [143:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// status[2:0], slot_index[7:3], level_out[16:8], removed_count[22:17]
	output logic [23:0]       m_tdata
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	fsm_t state_q, state_d;
	logic [IW-1:0] pos_q;
	logic [CW-1:0] cnt_q;

	// request registers
	op_t                  op_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [TIME_BITS-1:0] exp_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 rule_q;
	logic [7:0]           lvl_q;
	logic                 ok_q;

	// walk results
	logic                 dup_q, free_q, hit_q;
	logic [IW-1:0]        free_idx_q;
	logic [LEVEL_BITS-1:0] hit_lvl_q;
	logic [5:0]           rem_q;
	logic                 fill_lap_q;

	logic                  used  [ENTRIES];
	logic [KEY_BITS-1:0]   ckey  [ENTRIES];
	logic [TIME_BITS-1:0]  cexp  [ENTRIES];
	logic                  cunl  [ENTRIES];
	logic                  crule [ENTRIES];
	logic [LEVEL_BITS-1:0] clvl  [ENTRIES];

	logic shift;
	logic last;
	logic h_used, h_match, h_expire;
	logic n_used, n_unl, n_rule;
	logic [KEY_BITS-1:0] n_key;
	logic [TIME_BITS-1:0] n_exp;
	logic [LEVEL_BITS-1:0] n_lvl;
	logic fill_go;

	assign shift = (state_q == FSM_WALK);
	assign last  = (pos_q == IW'(ENTRIES - 1));

	// Head is cell 0; its data leaves to the tail after edit.
	assign h_used   = used[0];
	assign h_match  = h_used && (ckey[0] == key_q);
	assign h_expire = h_used && !cunl[0] && (cexp[0] <= now_q);

	always_comb begin
		n_used = h_used;
		n_key  = ckey[0];
		n_exp  = cexp[0];
		n_unl  = cunl[0];
		n_rule = crule[0];
		n_lvl  = clvl[0];
		case (op_q)
			OP_DELETE: if (ok_q && h_match) n_used = 1'b0;
			OP_TICK:   if (h_expire) n_used = 1'b0;
			OP_ADD: begin
				// fill the chosen slot on the second lap
				if (ok_q && fill_lap_q && (pos_q == free_idx_q)) begin
					n_used = 1'b1;
					n_key  = key_q;
					n_exp  = exp_q;
					n_unl  = (exp_q == '0);
					n_rule = rule_q;
					n_lvl  = LEVEL_BITS'(lvl_q) + (rule_q ? LEVEL_BITS'(LEVEL_STEP) : '0);
				end
			end
			default: ;
		endcase
	end

	// second lap only when the whole first lap saw no duplicate and a free slot
	assign fill_go = (op_q == OP_ADD) && ok_q && !fill_lap_q && !dup_q && !(h_match)
		&& (free_q || !h_used) && (cnt_q != CW'(ENTRIES));

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			localparam int NX = (g + 1) % ENTRIES;
			logic           iu;
			logic [KEY_BITS-1:0] ik;
			logic [TIME_BITS-1:0] ie;
			logic           iunl, ir;
			logic [LEVEL_BITS-1:0] il;
			if (g == ENTRIES - 1) begin : g_tail
				assign iu = n_used; assign ik = n_key; assign ie = n_exp;
				assign iunl = n_unl; assign ir = n_rule;
				assign il = n_lvl;
			end else begin : g_mid
				assign iu = used[NX]; assign ik = ckey[NX]; assign ie = cexp[NX];
				assign iunl = cunl[NX]; assign ir = crule[NX]; assign il = clvl[NX];
			end
			kttx_cell #(.KEY_BITS(KEY_BITS), .TIME_BITS(TIME_BITS)) u_cell (
				.clk(clk), .arst_n(arst_n), .shift(shift),
				.in_used(iu), .in_key(ik), .in_exp(ie), .in_unl(iunl), .in_rule(ir),
				.in_lvl(il),
				.used_q(used[g]), .key_q(ckey[g]), .exp_q(cexp[g]), .unl_q(cunl[g]),
				.rule_q(crule[g]), .lvl_q(clvl[g])
			);
		end
	endgenerate

	logic out_free;
	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (state_q == FSM_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: if (s_tvalid) state_d = FSM_WALK;
			FSM_WALK: if (last && !fill_go) state_d = FSM_DONE;
			FSM_DONE: if (out_free) state_d = FSM_IDLE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic del_now;
	assign del_now = (op_q == OP_DELETE) && ok_q && h_match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; cnt_q <= '0; fill_lap_q <= 1'b0;
			dup_q <= 1'b0; free_q <= 1'b0; hit_q <= 1'b0;
			rem_q <= '0;
		end else if (state_q == FSM_IDLE && s_tvalid) begin
			pos_q <= '0; fill_lap_q <= 1'b0;
			dup_q <= 1'b0; free_q <= 1'b0; hit_q <= 1'b0;
			rem_q <= '0;
		end else if (shift) begin
			pos_q <= last ? '0 : pos_q + IW'(1);
			if (fill_lap_q) begin
				if (pos_q == free_idx_q) cnt_q <= cnt_q + CW'(1);
			end else begin
				if (h_match) dup_q <= 1'b1;
				if (!h_used) free_q <= 1'b1;
				if (!hit_q && h_match && crule[0] == rule_q && op_q == OP_LOOKUP) hit_q <= 1'b1;
				if (del_now) cnt_q <= cnt_q - CW'(1);
				if (op_q == OP_TICK && h_expire) begin
					rem_q <= rem_q + 6'd1;
					cnt_q <= cnt_q - CW'(1);
				end
				if (last && fill_go) fill_lap_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_IDLE && s_tvalid) begin
			op_q   <= op_t'(s_tdata[1:0]);
			key_q  <= KEY_BITS'(s_tdata[65:2]);
			exp_q  <= TIME_BITS'(s_tdata[97:66]);
			now_q  <= TIME_BITS'(s_tdata[129:98]);
			rule_q <= s_tdata[130];
			lvl_q  <= s_tdata[138:131];
			ok_q   <= (s_tdata[1:0] == OP_LOOKUP && !s_tdata[139]) ? s_tdata[140]
				: (KEY_BITS'(s_tdata[65:2]) != '0);
		end else if (shift && !fill_lap_q) begin
			if (!free_q && !h_used) free_idx_q <= pos_q;
			if (!hit_q && h_match && crule[0] == rule_q) hit_lvl_q <= clvl[0];
		end
	end

	status_t st;
	always_comb begin
		st = ST_OK;
		case (op_q)
			OP_ADD:
				if (!ok_q) st = ST_INVALID;
				else if (dup_q) st = ST_DUP;
				else if (!fill_lap_q) st = ST_FULL;
			OP_DELETE:
				if (!ok_q) st = ST_INVALID;
				else if (!dup_q) st = ST_MISSING;
			default: st = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == FSM_DONE && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_DONE && out_free) begin
			m_tdata <= {1'b0,
				(op_q == OP_TICK) ? rem_q : 6'd0,
				(op_q == OP_LOOKUP && ok_q && hit_q) ? hit_lvl_q : LEVEL_BITS'(0),
				(st == ST_OK && op_q == OP_ADD) ? 5'(free_idx_q) : 5'd0,
				st};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(ENTRIES))
		else $error("occupancy above table size");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_IDLE) |-> (pos_q == '0 || $past(state_q) != FSM_WALK))
		else $error("walk left unfinished");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_WALK) |-> !s_tready)
		else $error("request taken during walk");
endmodule
`default_nettype wire
